/* hdl/sqbd_pkg.sv */
`default_nettype none
package sqbd_pkg;

  typedef enum logic [1:0] {
    KIND_ASSIGNED = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_SERVED   = 2'd2,
    KIND_IDLE     = 2'd3
  } kind_t;

  localparam logic       MODE_ARRIVE = 1'b0;
  localparam logic       MODE_TICK   = 1'b1;
  localparam logic [0:0] CFG_REGULAR = 1'b0;
  localparam logic [0:0] CFG_MEMBER  = 1'b1;

  // one queued command between front and back
  typedef struct packed {
    logic        mode;
    logic [15:0] id;
    logic [3:0]  stime;
    logic        pool;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARR_SCAN,
    ST_ARR_DONE,
    ST_TICK_READ,
    ST_TICK_WAIT,
    ST_TICK_ACT,
    ST_TICK_END
  } state_t;

endpackage
`default_nettype wire

/* hdl/shortest_queue_booth_dispatcher.sv */
`default_nettype none
// Join-shortest-queue dispatcher over two booth pools. A command is taken
// when start is high and busy low; a two-entry command queue lets commands
// be taken while work is in progress, and busy is high only when it is full.
// An arrival gives its result after a serial scan of the pool's waiting
// counts; a tick visits each booth in turn, and a non-empty booth goes
// through read, wait for the store and act, since the waiting store has a
// single read port. Results appear on out_valid for one cycle each and
// cannot be stalled; out_last marks the final result of a command.
module shortest_queue_booth_dispatcher #(
  parameter int MAX_BOOTHS  = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire         in_mode,
  input  wire  [15:0] in_customer_id,
  input  wire  [3:0]  in_service_time,
  input  wire         in_is_member,
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [3:0]  cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic        out_pool,
  output logic [2:0]  out_booth,
  output logic [15:0] out_served_id,
  output logic [31:0] out_served_total,
  output logic        out_last
);

  logic [3:0] regular_r, member_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regular_r <= '0;
      member_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sqbd_pkg::CFG_REGULAR: regular_r <= cfg_data;
        sqbd_pkg::CFG_MEMBER:  member_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic           q_valid, q_pop;
  sqbd_pkg::cmd_t q_cmd;

  sqbd_front u_front (
    .clk, .rst_n, .start, .busy, .in_mode, .in_customer_id,
    .in_service_time, .in_is_member, .q_valid, .q_cmd, .q_pop
  );

  sqbd_back #(.MAX_BOOTHS(MAX_BOOTHS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk, .rst_n, .regular_booths(regular_r), .member_booths(member_r),
    .q_valid, .q_cmd, .q_pop, .out_valid, .out_kind, .out_pool, .out_booth,
    .out_served_id, .out_served_total, .out_last
  );

endmodule
`default_nettype wire

/* hdl/sqbd_front.sv */
`default_nettype none
// accepts commands into a two-entry queue
module sqbd_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire               in_mode,
  input  wire        [15:0] in_customer_id,
  input  wire        [3:0]  in_service_time,
  input  wire               in_is_member,
  output logic              q_valid,
  output sqbd_pkg::cmd_t    q_cmd,
  input  wire               q_pop
);

  sqbd_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       push;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
    rd_nxt  = q_pop ? ~rd_r : rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[rd_r ^ cnt_r[0]] <= '{mode: in_mode, id: in_customer_id,
                                stime: in_service_time, pool: in_is_member};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> busy) else $error("full but not busy");
`endif

endmodule
`default_nettype wire

/* hdl/sqbd_back.sv */
`default_nettype none
// executes arrivals (serial count scan) and ticks (booths read one at a time)
module sqbd_back #(
  parameter int MAX_BOOTHS  = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire         [3:0]  regular_booths,
  input  wire         [3:0]  member_booths,
  input  wire                q_valid,
  input  sqbd_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  output logic        [1:0]  out_kind,
  output logic               out_pool,
  output logic        [2:0]  out_booth,
  output logic        [15:0] out_served_id,
  output logic        [31:0] out_served_total,
  output logic               out_last
);

  localparam int BW  = (MAX_BOOTHS > 1) ? $clog2(MAX_BOOTHS) : 1;
  localparam int NQ  = 2 * MAX_BOOTHS;
  localparam int QW  = $clog2(NQ);
  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int AW  = QW + PW;
  localparam int NW  = $clog2(MAX_BOOTHS + 1);

  logic [19:0]   mem [NQ*(2**PW)];
  logic [PW-1:0] head_r [NQ];
  logic [CW-1:0] cnt_r  [NQ];
  logic [31:0]   total_r;

  sqbd_pkg::state_t st_r, st_nxt;
  sqbd_pkg::cmd_t   cmd_r;
  logic [BW:0]      b_r;      // scan index
  logic [BW-1:0]    best_r;
  logic             p_r;      // pool during tick
  logic             any_r;
  logic [19:0]      rdata_r;
  logic [AW-1:0]    raddr;

  // a served result is held until the next one or the tick's end so that the last flag can be known
  logic        pend_r;
  logic        pend_pool_r;
  logic [2:0]  pend_booth_r;
  logic [15:0] pend_id_r;
  logic [31:0] pend_total_r;

  // clamped booth counts
  logic [NW-1:0] nreg, nmem, ncur, ntick;
  assign nreg = (int'(regular_booths) > MAX_BOOTHS) ? NW'(MAX_BOOTHS) : NW'(regular_booths);
  assign nmem = (int'(member_booths) > MAX_BOOTHS) ? NW'(MAX_BOOTHS) : NW'(member_booths);
  assign ncur  = cmd_r.pool ? nmem : nreg;
  assign ntick = p_r ? nmem : nreg;

  logic [QW-1:0] qscan, qbest, qtick;
  assign qscan = QW'(cmd_r.pool) * QW'(MAX_BOOTHS) + QW'(b_r[BW-1:0]);
  assign qbest = QW'(cmd_r.pool) * QW'(MAX_BOOTHS) + QW'(best_r);
  assign qtick = QW'(p_r) * QW'(MAX_BOOTHS) + QW'(b_r[BW-1:0]);
  assign raddr = {qtick, head_r[qtick]};

  logic scan_end, tick_pool_end;
  assign scan_end      = (NW'(b_r) >= ncur);
  assign tick_pool_end = (NW'(b_r) >= ntick);

  // tail slot: head plus count, wrapped once
  logic [PW:0]   wsum;
  logic [PW-1:0] wslot;
  assign wsum  = (PW+1)'(head_r[qbest]) + (PW+1)'(cnt_r[qbest]);
  assign wslot = (wsum >= (PW+1)'(QUEUE_DEPTH)) ? PW'(wsum - (PW+1)'(QUEUE_DEPTH)) :
                 PW'(wsum);

  logic full, nobooth;
  assign nobooth = (ncur == '0);
  assign full    = (cnt_r[qbest] >= CW'(QUEUE_DEPTH));

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      sqbd_pkg::ST_IDLE:
        if (q_valid) st_nxt = (q_cmd.mode == sqbd_pkg::MODE_TICK) ?
                              sqbd_pkg::ST_TICK_READ : sqbd_pkg::ST_ARR_SCAN;
      sqbd_pkg::ST_ARR_SCAN: if (scan_end) st_nxt = sqbd_pkg::ST_ARR_DONE;
      sqbd_pkg::ST_ARR_DONE: st_nxt = sqbd_pkg::ST_IDLE;
      sqbd_pkg::ST_TICK_READ: begin
        if (tick_pool_end) st_nxt = p_r ? sqbd_pkg::ST_TICK_END : sqbd_pkg::ST_TICK_READ;
        else if (cnt_r[qtick] != '0) st_nxt = sqbd_pkg::ST_TICK_WAIT;
      end
      sqbd_pkg::ST_TICK_WAIT: st_nxt = sqbd_pkg::ST_TICK_ACT;
      sqbd_pkg::ST_TICK_ACT:  st_nxt = sqbd_pkg::ST_TICK_READ;
      sqbd_pkg::ST_TICK_END:  st_nxt = sqbd_pkg::ST_IDLE;
      default: st_nxt = sqbd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  logic serve;
  assign serve = (st_r == sqbd_pkg::ST_TICK_ACT) && (rdata_r[3:0] == 4'd0);
  assign q_pop = (st_r == sqbd_pkg::ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= sqbd_pkg::ST_IDLE;
      total_r   <= '0;
      out_valid <= 1'b0;
      b_r       <= '0;
      p_r       <= 1'b0;
      any_r     <= 1'b0;
      best_r    <= '0;
      pend_r    <= 1'b0;
      for (int i = 0; i < NQ; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      st_r      <= st_nxt;
      out_valid <= 1'b0;
      case (st_r)
        sqbd_pkg::ST_IDLE: begin
          if (q_valid) begin
            b_r    <= (BW+1)'(1);
            best_r <= '0;
            p_r    <= 1'b0;
            any_r  <= 1'b0;
            if (q_cmd.mode == sqbd_pkg::MODE_TICK) b_r <= '0;
          end
        end
        sqbd_pkg::ST_ARR_SCAN: begin
          if (!scan_end) begin
            if (cnt_r[qscan] < cnt_r[qbest]) best_r <= b_r[BW-1:0];
            b_r <= b_r + 1'b1;
          end
        end
        sqbd_pkg::ST_ARR_DONE: begin
          out_valid        <= 1'b1;
          out_pool         <= cmd_r.pool;
          out_served_id    <= cmd_r.id;
          out_served_total <= total_r;
          out_last         <= 1'b1;
          out_booth        <= nobooth ? 3'd0 : 3'(best_r);
          if (nobooth || full) begin
            out_kind <= sqbd_pkg::KIND_REJECTED;
          end else begin
            out_kind     <= sqbd_pkg::KIND_ASSIGNED;
            cnt_r[qbest] <= cnt_r[qbest] + 1'b1;
          end
        end
        sqbd_pkg::ST_TICK_READ: begin
          if (tick_pool_end) begin
            b_r <= '0;
            p_r <= 1'b1;
          end else if (cnt_r[qtick] == '0) begin
            b_r <= b_r + 1'b1;
          end
        end
        sqbd_pkg::ST_TICK_ACT: begin
          b_r <= b_r + 1'b1;
          if (serve) begin
            head_r[qtick] <= (head_r[qtick] == PW'(QUEUE_DEPTH - 1)) ? '0 :
                             head_r[qtick] + 1'b1;
            cnt_r[qtick]  <= cnt_r[qtick] - 1'b1;
            total_r       <= total_r + 1'b1;
            any_r         <= 1'b1;
          end
        end
        default: ;
      endcase
      if (st_r == sqbd_pkg::ST_TICK_END && !any_r) begin
        out_valid        <= 1'b1;
        out_kind         <= sqbd_pkg::KIND_IDLE;
        out_pool         <= 1'b0;
        out_booth        <= '0;
        out_served_id    <= '0;
        out_served_total <= total_r;
        out_last         <= 1'b1;
      end
      if (serve) begin
        pend_r       <= 1'b1;
        pend_pool_r  <= p_r;
        pend_booth_r <= 3'(b_r[BW-1:0]);
        pend_id_r    <= rdata_r[19:4];
        pend_total_r <= total_r + 1'b1;
      end else if (st_r == sqbd_pkg::ST_TICK_END) begin
        pend_r <= 1'b0;
      end
      if (pend_r && (serve || st_r == sqbd_pkg::ST_TICK_END)) begin
        out_valid        <= 1'b1;
        out_kind         <= sqbd_pkg::KIND_SERVED;
        out_pool         <= pend_pool_r;
        out_booth        <= pend_booth_r;
        out_served_id    <= pend_id_r;
        out_served_total <= pend_total_r;
        out_last         <= (st_r == sqbd_pkg::ST_TICK_END);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_cmd;
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (st_r == sqbd_pkg::ST_ARR_DONE && !nobooth && !full) begin
      mem[{qbest, wslot}] <= {cmd_r.id, cmd_r.stime};
    end else if (st_r == sqbd_pkg::ST_TICK_ACT && !serve) begin
      mem[raddr] <= rdata_r - 20'd1;
    end
    rdata_r <= mem[raddr];
  end

`ifndef SYNTHESIS
  a_one_hot_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == sqbd_pkg::KIND_IDLE) |-> out_last)
    else $error("idle tick result not last");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[qbest] <= CW'(QUEUE_DEPTH)) else $error("count overflow");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (st_r != sqbd_pkg::ST_IDLE)) else $error("pop without work");
`endif

endmodule
`default_nettype wire

/* tb/shortest_queue_booth_dispatcher_test.sv */
`timescale 1ns / 1ps
module shortest_queue_booth_dispatcher_test;

  localparam int BOOTHS = 8;
  localparam int DEPTH  = 64;

  typedef struct {
    sqbd_pkg::kind_t kind;
    logic        pool;
    logic [2:0]  booth;
    logic [15:0] id;
    logic [31:0] total;
    logic        last;
  } outcome_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_mode;
  logic [15:0] in_customer_id;
  logic [3:0]  in_service_time;
  logic        in_is_member;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [3:0]  cfg_data;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic        out_pool;
  logic [2:0]  out_booth;
  logic [15:0] out_served_id;
  logic [31:0] out_served_total;
  logic        out_last;

  shortest_queue_booth_dispatcher DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_customer_id(in_customer_id),
    .in_service_time(in_service_time), .in_is_member(in_is_member),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_kind(out_kind), .out_pool(out_pool),
    .out_booth(out_booth), .out_served_id(out_served_id),
    .out_served_total(out_served_total), .out_last(out_last)
  );

  // shadow of the booth state
  logic [15:0] slot_id   [2*BOOTHS][DEPTH];
  logic [3:0]  slot_time [2*BOOTHS][DEPTH];
  int unsigned head_slot [2*BOOTHS];
  int unsigned occupancy [2*BOOTHS];
  logic [31:0] served_count;
  logic [3:0]  regular_cfg;
  logic [3:0]  member_cfg;

  sqbd_pkg::cmd_t pending_cmds[$];
  outcome_t       expected_outcomes[$];
  int             fail_count;
  int             gap_left;
  bit             no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned active_booths(logic pool);
    logic [3:0] n;
    n = pool ? member_cfg : regular_cfg;
    return (n > BOOTHS) ? BOOTHS : n;
  endfunction

  function automatic void push_outcome(sqbd_pkg::kind_t k, logic pool, int unsigned b,
                                       logic [15:0] id, logic last);
    outcome_t o;
    o.kind  = k;
    o.pool  = pool;
    o.booth = b[2:0];
    o.id    = id;
    o.total = served_count;
    o.last  = last;
    expected_outcomes.push_back(o);
  endfunction

  function automatic void dispatch_predict(sqbd_pkg::cmd_t c);
    int unsigned n, best, q, h, hits;
    outcome_t o;
    if (c.mode == sqbd_pkg::MODE_ARRIVE) begin
      n = active_booths(c.pool);
      if (n == 0) begin
        push_outcome(sqbd_pkg::KIND_REJECTED, c.pool, 0, c.id, 1'b1);
        return;
      end
      best = 0;
      for (int b = 1; b < n; b++)
        if (occupancy[c.pool*BOOTHS + b] < occupancy[c.pool*BOOTHS + best]) best = b;
      q = c.pool*BOOTHS + best;
      if (occupancy[q] >= DEPTH) begin
        push_outcome(sqbd_pkg::KIND_REJECTED, c.pool, best, c.id, 1'b1);
        return;
      end
      h = (head_slot[q] + occupancy[q]) % DEPTH;
      slot_id[q][h]   = c.id;
      slot_time[q][h] = c.stime;
      occupancy[q]++;
      push_outcome(sqbd_pkg::KIND_ASSIGNED, c.pool, best, c.id, 1'b1);
    end else begin
      hits = 0;
      for (int p = 0; p < 2; p++) begin
        n = active_booths(p[0]);
        for (int b = 0; b < n; b++) begin
          q = p*BOOTHS + b;
          if (occupancy[q] != 0) begin
            h = head_slot[q];
            if (slot_time[q][h] == 0) begin
              head_slot[q] = (h + 1) % DEPTH;
              occupancy[q]--;
              served_count++;
              push_outcome(sqbd_pkg::KIND_SERVED, p[0], b, slot_id[q][h], 1'b0);
              hits++;
            end else begin
              slot_time[q][h]--;
            end
          end
        end
      end
      if (hits == 0) begin
        push_outcome(sqbd_pkg::KIND_IDLE, 1'b0, 0, 16'h0, 1'b1);
      end else begin
        o = expected_outcomes.pop_back();
        o.last = 1'b1;
        expected_outcomes.push_back(o);
      end
    end
  endfunction

  // command driver
  always @(posedge clk) begin
    sqbd_pkg::cmd_t c;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        c.mode  = in_mode;
        c.id    = in_customer_id;
        c.stime = in_service_time;
        c.pool  = in_is_member;
        dispatch_predict(c);
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        if (!no_gaps && $urandom_range(0, 7) == 0) begin
          gap_left <= int'($urandom_range(1, 9)) - 1;
          start    <= 1'b0;
        end else begin
          c = pending_cmds.pop_front();
          in_mode         <= c.mode;
          in_customer_id  <= c.id;
          in_service_time <= c.stime;
          in_is_member    <= c.pool;
          start           <= 1'b1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid) begin
      if (expected_outcomes.size() == 0) begin
        $error("unexpected transaction: kind %0d id %h", out_kind, out_served_id);
        fail_count++;
      end else begin
        e = expected_outcomes.pop_front();
        if (out_kind !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, out_kind); fail_count++;
        end
        if (out_pool !== e.pool) begin
          $error("pool: expected %0d actual %0d", e.pool, out_pool); fail_count++;
        end
        if (out_booth !== e.booth) begin
          $error("booth: expected %0d actual %0d", e.booth, out_booth); fail_count++;
        end
        if (out_served_id !== e.id) begin
          $error("served_id: expected %h actual %h", e.id, out_served_id); fail_count++;
        end
        if (out_served_total !== e.total) begin
          $error("served_total: expected %0d actual %0d", e.total, out_served_total);
          fail_count++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, out_last); fail_count++;
        end
      end
    end
  end

  function automatic void queue_cmd(logic mode, logic [15:0] id, logic [3:0] st,
                                    logic pool);
    sqbd_pkg::cmd_t c;
    c.mode  = mode;
    c.id    = id;
    c.stime = st;
    c.pool  = pool;
    pending_cmds.push_back(c);
  endfunction

  // mix of arrivals and ticks; service times mostly short so customers leave
  function automatic void queue_random(int count, int arrive_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < arrive_pct)
        queue_cmd(sqbd_pkg::MODE_ARRIVE, 16'($urandom()),
                  ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                                                4'($urandom_range(0, 2)),
                  1'($urandom_range(0, 1)));
      else
        queue_cmd(sqbd_pkg::MODE_TICK, 16'($urandom()), 4'($urandom()),
                  1'($urandom_range(0, 1)));
    end
  endfunction

  task automatic drain;
    while (pending_cmds.size() != 0 || start || expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_booths(logic [3:0] regular, logic [3:0] member);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sqbd_pkg::CFG_REGULAR;
    cfg_data  <= regular;
    @(posedge clk);
    cfg_index <= sqbd_pkg::CFG_MEMBER;
    cfg_data  <= member;
    @(posedge clk);
    cfg_we <= 1'b0;
    regular_cfg = regular;
    member_cfg  = member;
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_mode         = sqbd_pkg::MODE_ARRIVE;
    in_customer_id  = '0;
    in_service_time = '0;
    in_is_member    = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = sqbd_pkg::CFG_REGULAR;
    cfg_data        = '0;
    fail_count      = 0;
    no_gaps         = 1'b0;
    served_count    = '0;
    regular_cfg     = '0;
    member_cfg      = '0;
    for (int q = 0; q < 2*BOOTHS; q++) begin
      head_slot[q] = 0;
      occupancy[q] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // no booths at all: every arrival rejected, ticks serve nobody
    queue_cmd(sqbd_pkg::MODE_ARRIVE, 16'h0000, 4'h0, 1'b0);
    queue_cmd(sqbd_pkg::MODE_ARRIVE, 16'hffff, 4'hf, 1'b1);
    queue_cmd(sqbd_pkg::MODE_TICK, 16'h0, 4'h0, 1'b0);
    drain();

    // counts above the booth limit clamp to eight
    set_booths(4'hf, 4'hf);
    for (int i = 0; i < 9; i++)
      queue_cmd(sqbd_pkg::MODE_ARRIVE, 16'(16'h1000 + i), (i == 8) ? 4'hf : 4'h0, 1'b0);
    queue_cmd(sqbd_pkg::MODE_ARRIVE, 16'hffff, 4'h1, 1'b1);
    queue_cmd(sqbd_pkg::MODE_ARRIVE, 16'h0000, 4'h0, 1'b1);
    for (int i = 0; i < 4; i++) queue_cmd(sqbd_pkg::MODE_TICK, 16'hffff, 4'hf, 1'b1);
    drain();

    // one booth per pool: fill the regular one past full
    set_booths(4'd1, 4'd1);
    for (int i = 0; i < 66; i++)
      queue_cmd(sqbd_pkg::MODE_ARRIVE, 16'($urandom()), 4'h0, 1'b0);
    queue_random(40, 30);
    drain();

    // lowered counts leave stranded queues until they come back
    set_booths(4'd8, 4'd3);
    queue_random(60, 55);
    drain();
    set_booths(4'd4, 4'd0);
    queue_random(60, 50);
    drain();
    set_booths(4'd0, 4'd8);
    queue_random(60, 50);
    drain();
    set_booths(4'd2, 4'd9);
    queue_random(60, 50);
    drain();
    set_booths(4'd8, 4'd8);
    queue_random(60, 45);
    drain();
    no_gaps = 1'b1;
    set_booths(4'd3, 4'd5);
    queue_random(60, 50);
    drain();
    repeat (100) @(posedge clk);

    if (fail_count == 0)
      $display("shortest_queue_booth_dispatcher: match");
    else
      $display("shortest_queue_booth_dispatcher: mismatch");
    $finish;
  end

  initial begin
    #5ms;
    $display("shortest_queue_booth_dispatcher: mismatch");
    $finish;
  end

endmodule
